// ===== hw/rtl/rot_pkg.sv =====
// Shared types, codes and the corner helper of the raster outline tracer.
// No dependencies.
package rot_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;

  // Configuration register indexes
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_BG_OPACITY   = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_X     = 3'd3;
  localparam logic [2:0] CFG_ORIGIN_Y     = 3'd4;
  localparam logic [2:0] CFG_SKIP_HOLES   = 3'd5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_NEXT  = 2'd1,
    OP_FRAME = 2'd2
  } rot_op_e;

  typedef enum logic [2:0] {
    E_RIGHT  = 3'd0,
    E_TOP    = 3'd1,
    E_LEFT   = 3'd2,
    E_BOTTOM = 3'd3,
    E_NONE   = 3'd4
  } rot_edge_e;

  typedef struct packed {
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic [7:0]  background_opacity;
    logic [14:0] origin_x;
    logic [14:0] origin_y;
    logic        skip_holes;
  } rot_cfg_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } rot_xy_t;

  typedef struct packed {
    rot_xy_t xy;
    logic    last;
    logic    done;
  } rot_res_t;

  // Corner of an edge at pixel (c,r), offset by the origin
  function automatic rot_xy_t rot_corner(input logic [15:0] c, input logic [15:0] r,
                                         input rot_edge_e e, input logic [14:0] ox,
                                         input logic [14:0] oy);
    rot_xy_t     v;
    logic [15:0] cx;
    logic [15:0] cy;
    cx = c;
    cy = r;
    if (e inside {E_TOP, E_RIGHT}) begin
      cx = c + 16'd1;
    end
    if (e inside {E_BOTTOM, E_RIGHT}) begin
      cy = r + 16'd1;
    end
    v.x = cx + {ox[14], ox};
    v.y = cy + {oy[14], oy};
    return v;
  endfunction

endpackage

// ===== hw/rtl/rot_pixmem.sv =====
// Pixel opacity store: one write port, one registered read port.
// No package dependencies.
module rot_pixmem #(
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [2**AddrW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rot_markmem.sv =====
// Edge mark store (four bits per pixel) with a clearing sweep after reset
// and on request. No package dependencies.
module rot_markmem #(
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  output logic             busy_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [3:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [3:0]       rdata_o
);

  logic [3:0]       mem [2**AddrW];
  logic [3:0]       rdata_q;
  logic             busy_q;
  logic [AddrW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (clear_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + AddrW'(1);
      if (&cnt_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[cnt_q] <= 4'd0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rot_tracer.sv =====
// Tracing sequencer: scan, edge following and corner hold-back.
// Uses rot_pkg, rot_pixmem and rot_markmem.
module rot_tracer #(
  parameter int unsigned MaxWidth  = rot_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = rot_pkg::DefMaxHeight
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rot_pkg::rot_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [7:0]        pixel_col_i,
  input  logic [7:0]        pixel_row_i,
  input  logic [7:0]        opacity_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output rot_pkg::rot_res_t res_o
);
  import rot_pkg::*;

  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned RW = $clog2(MaxHeight);
  localparam int unsigned AW = CW + 1;
  localparam int unsigned AH = RW + 1;
  localparam int unsigned MW = CW + RW;

  typedef enum logic [3:0] {
    S_IDLE, S_EVENT, S_FS, S_FS_C, S_FS_K, S_FS_N,
    S_TM, S_TRY, S_TRY_C, S_TRY_N, S_POST, S_EV, S_EMIT
  } state_e;

  typedef enum logic [1:0] {EV_VERTEX, EV_END, EV_DONE} ev_e;
  typedef enum logic [1:0] {CL_NONE, CL_CORNER, CL_END} close_e;

  state_e    state_q;
  logic [AW-1:0] scol_q, tcol_q, tgt_col_q;
  logic [AH-1:0] srow_q, trow_q, tgt_row_q;
  rot_edge_e cur_q, prev_q, start_q, tgt_e_q;
  logic      active_q, emit_q, hold_v_q, t_q, pr_oob_q;
  close_e    close_q;
  ev_e       ev_q;
  rot_xy_t   hold_q, evxy_q;
  rot_res_t  res_q;
  logic [1:0] k_q;

  logic [AW-1:0] act_w, adv_col, mv_col, pr_col;
  logic [AH-1:0] act_h, adv_row, mv_row, pr_row;
  rot_edge_e mv_e, k_edge, cur_next;
  logic      mv_oob, pr_go, pr_oob, bg_w, accept;
  logic      pix_we, pix_re, mk_we, mk_re, mk_clear, mk_busy;
  logic [MW-1:0] pix_waddr, pix_raddr, mk_raddr, trace_addr;
  logic [7:0]    pix_rdata;
  logic [3:0]    mk_rdata, mk_wdata;

  function automatic logic [AW-1:0] nb_col(input logic [AW-1:0] c, input rot_edge_e e);
    logic [AW-1:0] v;
    v = c;
    if (e == E_LEFT) begin
      v = c - AW'(1);
    end else if (e == E_RIGHT) begin
      v = c + AW'(1);
    end
    return v;
  endfunction

  function automatic logic [AH-1:0] nb_row(input logic [AH-1:0] r, input rot_edge_e e);
    logic [AH-1:0] v;
    v = r;
    if (e == E_TOP) begin
      v = r - AH'(1);
    end else if (e == E_BOTTOM) begin
      v = r + AH'(1);
    end
    return v;
  endfunction

  // Active frame size, saturated to the store size
  always_comb begin
    if (32'(cfg_i.image_width) > MaxWidth) begin
      act_w = AW'(MaxWidth);
    end else begin
      act_w = AW'(cfg_i.image_width);
    end
    if (32'(cfg_i.image_height) > MaxHeight) begin
      act_h = AH'(MaxHeight);
    end else begin
      act_h = AH'(cfg_i.image_height);
    end
  end

  always_comb begin
    adv_col = scol_q + AW'(1);
    adv_row = srow_q;
    if (adv_col >= act_w) begin
      adv_col = '0;
      adv_row = srow_q + AH'(1);
    end
  end

  assign k_edge   = rot_edge_e'({1'b0, k_q + 2'd1});
  assign cur_next = rot_edge_e'({1'b0, cur_q[1:0] + 2'd1});

  // Candidate move of the edge follower; t_q picks the second choice
  always_comb begin
    mv_col = tcol_q;
    mv_row = trow_q;
    mv_e   = E_RIGHT;
    case (cur_q)
      E_RIGHT: begin
        mv_row = trow_q - AH'(1);
        if (t_q) begin
          mv_col = tcol_q + AW'(1);
          mv_e   = E_BOTTOM;
        end
      end
      E_TOP: begin
        mv_col = tcol_q - AW'(1);
        mv_e   = E_TOP;
        if (t_q) begin
          mv_row = trow_q - AH'(1);
          mv_e   = E_RIGHT;
        end
      end
      E_LEFT: begin
        mv_row = trow_q + AH'(1);
        mv_e   = E_LEFT;
        if (t_q) begin
          mv_col = tcol_q - AW'(1);
          mv_e   = E_TOP;
        end
      end
      E_BOTTOM: begin
        mv_col = tcol_q + AW'(1);
        mv_e   = E_BOTTOM;
        if (t_q) begin
          mv_row = trow_q + AH'(1);
          mv_e   = E_LEFT;
        end
      end
      default: ;
    endcase
  end

  assign mv_oob = (mv_col >= act_w) || (mv_row >= act_h);

  // Background probe: out-of-frame positions (including -1) resolve without a read
  always_comb begin
    pr_go  = 1'b0;
    pr_col = scol_q;
    pr_row = srow_q;
    case (state_q)
      S_FS: pr_go = (srow_q < act_h) && (scol_q < act_w);
      S_FS_K: begin
        if (!mk_rdata[k_edge[1:0]]) begin
          pr_go  = 1'b1;
          pr_col = nb_col(scol_q, k_edge);
          pr_row = nb_row(srow_q, k_edge);
        end
      end
      S_TRY: begin
        pr_go  = !mv_oob;
        pr_col = mv_col;
        pr_row = mv_row;
      end
      S_TRY_C: begin
        if (!bg_w) begin
          pr_go  = 1'b1;
          pr_col = nb_col(tgt_col_q, tgt_e_q);
          pr_row = nb_row(tgt_row_q, tgt_e_q);
        end
      end
      default: ;
    endcase
  end

  assign pr_oob    = (pr_col >= act_w) || (pr_row >= act_h);
  assign pix_re    = pr_go && !pr_oob;
  assign pix_raddr = {pr_row[RW-1:0], pr_col[CW-1:0]};
  assign bg_w      = pr_oob_q || (pix_rdata == cfg_i.background_opacity);

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && !mk_busy;
  assign pix_we     = accept && (op_i == OP_WRITE) && (32'(pixel_col_i) < MaxWidth)
                      && (32'(pixel_row_i) < MaxHeight);
  assign pix_waddr  = {RW'(pixel_row_i), CW'(pixel_col_i)};
  assign mk_clear   = accept && (op_i == OP_FRAME);

  assign trace_addr = {trow_q[RW-1:0], tcol_q[CW-1:0]};
  assign mk_re      = ((state_q == S_FS) && pr_go) ||
                      ((state_q == S_EVENT) && active_q && (close_q == CL_NONE)
                       && (cur_q != E_NONE));
  assign mk_raddr   = (state_q == S_FS) ? {srow_q[RW-1:0], scol_q[CW-1:0]} : trace_addr;
  assign mk_we      = (state_q == S_TM) && !mk_rdata[cur_q[1:0]];
  assign mk_wdata   = mk_rdata | (4'b0001 << cur_q[1:0]);

  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

  rot_pixmem #(.AddrW(MW)) u_pixmem (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (opacity_i),
    .re_i    (pix_re),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  rot_markmem #(.AddrW(MW)) u_markmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mk_clear),
    .busy_o  (mk_busy),
    .we_i    (mk_we),
    .waddr_i (trace_addr),
    .wdata_i (mk_wdata),
    .re_i    (mk_re),
    .raddr_i (mk_raddr),
    .rdata_o (mk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scol_q   <= '0;
      srow_q   <= '0;
      tcol_q   <= '0;
      trow_q   <= '0;
      cur_q    <= E_NONE;
      prev_q   <= E_NONE;
      start_q  <= E_NONE;
      active_q <= 1'b0;
      emit_q   <= 1'b0;
      close_q  <= CL_NONE;
      hold_v_q <= 1'b0;
      ev_q     <= EV_DONE;
      k_q      <= '0;
      t_q      <= 1'b0;
      pr_oob_q <= 1'b0;
    end else begin
      if (pr_go) begin
        pr_oob_q <= pr_oob;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_i)
              OP_NEXT: state_q <= S_EVENT;
              OP_FRAME: begin
                scol_q   <= '0;
                srow_q   <= '0;
                tcol_q   <= '0;
                trow_q   <= '0;
                cur_q    <= E_NONE;
                prev_q   <= E_NONE;
                start_q  <= E_NONE;
                active_q <= 1'b0;
                emit_q   <= 1'b0;
                close_q  <= CL_NONE;
                hold_v_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_EVENT: begin
          if (!active_q) begin
            state_q <= S_FS;
          end else if (close_q == CL_CORNER) begin
            close_q <= CL_END;
            if (emit_q) begin
              ev_q    <= EV_VERTEX;
              evxy_q  <= rot_corner(16'(scol_q), 16'(srow_q), E_NONE,
                                    cfg_i.origin_x, cfg_i.origin_y);
              state_q <= S_EV;
            end
          end else if (close_q == CL_END) begin
            active_q <= 1'b0;
            close_q  <= CL_NONE;
            scol_q   <= adv_col;
            srow_q   <= adv_row;
            ev_q     <= EV_END;
            state_q  <= S_EV;
          end else if (cur_q == E_NONE) begin
            close_q <= CL_END;
          end else begin
            state_q <= S_TM;
          end
        end
        S_FS: begin
          if (srow_q >= act_h) begin
            ev_q    <= EV_DONE;
            state_q <= S_EV;
          end else if (scol_q >= act_w) begin
            scol_q <= '0;
            srow_q <= srow_q + AH'(1);
          end else begin
            state_q <= S_FS_C;
          end
        end
        S_FS_C: begin
          if (bg_w) begin
            scol_q  <= adv_col;
            srow_q  <= adv_row;
            state_q <= S_FS;
          end else begin
            k_q     <= '0;
            state_q <= S_FS_K;
          end
        end
        S_FS_K, S_FS_N: begin
          if ((state_q == S_FS_K) && !mk_rdata[k_edge[1:0]]) begin
            state_q <= S_FS_N;
          end else if ((state_q == S_FS_N) && bg_w) begin
            // start edge found: open a trace here
            active_q <= 1'b1;
            tcol_q   <= scol_q;
            trow_q   <= srow_q;
            cur_q    <= k_edge;
            start_q  <= k_edge;
            close_q  <= CL_NONE;
            emit_q   <= !(cfg_i.skip_holes && (k_edge == E_BOTTOM));
            if (k_edge == E_BOTTOM) begin
              prev_q <= E_BOTTOM;
              if (!cfg_i.skip_holes) begin
                ev_q    <= EV_VERTEX;
                evxy_q  <= rot_corner(16'(scol_q), 16'(srow_q), E_BOTTOM,
                                      cfg_i.origin_x, cfg_i.origin_y);
                state_q <= S_EV;
              end else begin
                state_q <= S_EVENT;
              end
            end else begin
              prev_q  <= E_NONE;
              state_q <= S_EVENT;
            end
          end else if (k_q == 2'd3) begin
            scol_q  <= adv_col;
            srow_q  <= adv_row;
            state_q <= S_FS;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_FS_K;
          end
        end
        S_TM: begin
          if (mk_rdata[cur_q[1:0]]) begin
            close_q <= CL_END;   // broken outline
            state_q <= S_EVENT;
          end else begin
            t_q     <= 1'b0;
            state_q <= S_TRY;
          end
        end
        S_TRY, S_TRY_C, S_TRY_N: begin
          if ((state_q == S_TRY) && !mv_oob) begin
            tgt_col_q <= mv_col;
            tgt_row_q <= mv_row;
            tgt_e_q   <= mv_e;
            state_q   <= S_TRY_C;
          end else if ((state_q == S_TRY_C) && !bg_w) begin
            state_q <= S_TRY_N;
          end else if ((state_q == S_TRY_N) && bg_w) begin
            tcol_q  <= tgt_col_q;
            trow_q  <= tgt_row_q;
            cur_q   <= tgt_e_q;
            state_q <= S_POST;
          end else if (!t_q) begin
            t_q     <= 1'b1;
            state_q <= S_TRY;
          end else begin
            cur_q   <= cur_next;   // no move: turn in place
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if ((tcol_q == scol_q) && (trow_q == srow_q) && (cur_q == start_q)) begin
            close_q <= (start_q != E_BOTTOM) ? CL_CORNER : CL_END;
          end
          if ((prev_q != cur_q) && emit_q) begin
            prev_q  <= cur_q;
            ev_q    <= EV_VERTEX;
            evxy_q  <= rot_corner(16'(tcol_q), 16'(trow_q), cur_q,
                                  cfg_i.origin_x, cfg_i.origin_y);
            state_q <= S_EV;
          end else begin
            prev_q  <= cur_q;
            state_q <= S_EVENT;
          end
        end
        S_EV: begin
          case (ev_q)
            EV_VERTEX: begin
              hold_q <= evxy_q;
              if (hold_v_q) begin
                res_q   <= '{xy: hold_q, last: 1'b0, done: 1'b0};
                state_q <= S_EMIT;
              end else begin
                hold_v_q <= 1'b1;
                state_q  <= S_EVENT;
              end
            end
            EV_END: begin
              if (hold_v_q) begin
                hold_v_q <= 1'b0;
                res_q    <= '{xy: hold_q, last: 1'b1, done: 1'b0};
                state_q  <= S_EMIT;
              end else begin
                state_q <= S_EVENT;
              end
            end
            default: begin
              if (hold_v_q) begin
                hold_v_q <= 1'b0;
                res_q    <= '{xy: hold_q, last: 1'b1, done: 1'b0};
              end else begin
                res_q <= '{xy: '0, last: 1'b0, done: 1'b1};
              end
              state_q <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_mark_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mk_we |-> !mk_busy)
    else $error("mark write during clearing sweep");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mk_clear |=> mk_busy && !in_ready_o)
    else $error("input taken while marks are being cleared");

  a_pix_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_we |-> !pix_re)
    else $error("pixel store read and written in one cycle");

endmodule

// ===== hw/rtl/raster_outline_tracer_top.sv =====
// Top level of the raster outline tracer: configuration registers,
// output register and the tracing sequencer. Uses rot_pkg and rot_tracer.
//
// Load a frame with write items (op 0), start a frame with op 2, then send
// next-vertex items (op 1); each returns one corner with polygon_last set on
// the corner that closes a polygon, or frame_done once nothing is left.
// A next-vertex item scans pixels for a start edge when no trace is open,
// reading the pixel and mark memories, then follows outline edges one by
// one and hands the corner over to the output register. After reset and
// after every frame start, the mark memory is swept clear (MaxWidth*MaxHeight
// entries, rounded up to powers of two, 65536 at the default size); no item
// is taken during the sweep, though configuration writes are. Configuration
// must be written only while the block is idle; the block does not enforce it.
// The next item is taken while a result still waits in the output register.
module raster_outline_tracer_top #(
  parameter int unsigned MaxWidth  = rot_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = rot_pkg::DefMaxHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         pixel_col_i,
  input  logic [7:0]         pixel_row_i,
  input  logic [7:0]         opacity_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] vertex_x_o,
  output logic signed [15:0] vertex_y_o,
  output logic               polygon_last_o,
  output logic               frame_done_o
);
  import rot_pkg::*;

  rot_cfg_t cfg_q;
  rot_res_t res;
  rot_res_t out_q;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width        <= 9'd256;
      cfg_q.image_height       <= 9'd256;
      cfg_q.background_opacity <= 8'd0;
      cfg_q.origin_x           <= 15'd0;
      cfg_q.origin_y           <= 15'd0;
      cfg_q.skip_holes         <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_q.image_width        <= cfg_wdata_i[8:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height       <= cfg_wdata_i[8:0];
        CFG_BG_OPACITY:   cfg_q.background_opacity <= cfg_wdata_i[7:0];
        CFG_ORIGIN_X:     cfg_q.origin_x           <= cfg_wdata_i;
        CFG_ORIGIN_Y:     cfg_q.origin_y           <= cfg_wdata_i;
        CFG_SKIP_HOLES:   cfg_q.skip_holes         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  rot_tracer #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_tracer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .opacity_i   (opacity_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_x_o     = out_q.xy.x;
  assign vertex_y_o     = out_q.xy.y;
  assign polygon_last_o = out_q.last;
  assign frame_done_o   = out_q.done;

endmodule

// ===== tb/raster_outline_tracer_top_test.sv =====
// Testbench of raster_outline_tracer_top: loads frames, traces them and
// checks each corner against a predictor kept in step with accepted items.
// Depends on rot_pkg and the RTL top level only.
`timescale 1ns / 100ps

module raster_outline_tracer_top_test;
  import rot_pkg::*;

  localparam int unsigned Dim       = 256;
  localparam int unsigned StallCap  = 400000;  // idle cycles allowed before the watchdog stops the run
  localparam int unsigned Settle    = 40;      // cycles after the last result

  typedef struct packed {
    rot_op_e    op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] opa;
  } pix_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [14:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         op_i;
  logic [7:0]         pixel_col_i;
  logic [7:0]         pixel_row_i;
  logic [7:0]         opacity_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] vertex_x_o;
  logic signed [15:0] vertex_y_o;
  logic               polygon_last_o;
  logic               frame_done_o;

  raster_outline_tracer_top DUT (.*);

  // ---------------------------------------------------------------------
  // Outline predictor: own copy of the frame, the marks and the tracer.
  // ---------------------------------------------------------------------
  logic [7:0]  frame_px [Dim*Dim];
  logic [3:0]  edge_seen [Dim*Dim];
  int unsigned act_cols, act_rows;
  logic [7:0]  bg_level;
  logic [14:0] org_x, org_y;
  logic        drop_holes;

  int          scan_c, scan_r, walk_c, walk_r;
  rot_edge_e   walk_e, last_turn_e, first_e;
  bit          walking, walk_shown, held;
  int          close_step;
  rot_xy_t     held_xy;
  int          dones_seen;  // frame_done results predicted since the last frame start

  pix_req_t    item_q [$];   // items waiting to be driven
  rot_res_t    vertex_q [$]; // predicted results not yet seen
  int          fails;

  function automatic void queue_item(pix_req_t it);
    item_q = {item_q, it};
  endfunction

  function automatic int cols_used();
    return (act_cols > Dim) ? Dim : act_cols;
  endfunction

  function automatic int rows_used();
    return (act_rows > Dim) ? Dim : act_rows;
  endfunction

  function automatic bit is_empty(int c, int r);
    if (c < 0 || r < 0 || c >= cols_used() || r >= rows_used()) return 1'b1;
    return frame_px[r*Dim + c] == bg_level;
  endfunction

  function automatic bit on_outline(rot_edge_e e, int c, int r);
    if (is_empty(c, r)) return 1'b0;
    case (e)
      E_LEFT:   return c == 0 || is_empty(c - 1, r);
      E_TOP:    return r == 0 || is_empty(c, r - 1);
      E_RIGHT:  return c + 1 == cols_used() || is_empty(c + 1, r);
      E_BOTTOM: return r + 1 == rows_used() || is_empty(c, r + 1);
      default:  return 1'b0;
    endcase
  endfunction

  function automatic bit step_to(int dr, int dc, rot_edge_e e);
    int r;
    int c;
    r = walk_r + dr;
    c = walk_c + dc;
    if (r < 0 || c < 0 || r >= rows_used() || c >= cols_used()) return 1'b0;
    if (!on_outline(e, c, r)) return 1'b0;
    walk_r = r;
    walk_c = c;
    walk_e = e;
    return 1'b1;
  endfunction

  function automatic void walk_edge();
    bit moved;
    moved = 1'b0;
    case (walk_e)
      E_RIGHT:  moved = step_to(-1, 0, E_RIGHT) || step_to(-1, 1, E_BOTTOM);
      E_TOP:    moved = step_to(0, -1, E_TOP) || step_to(-1, -1, E_RIGHT);
      E_LEFT:   moved = step_to(1, 0, E_LEFT) || step_to(1, -1, E_TOP);
      E_BOTTOM: moved = step_to(0, 1, E_BOTTOM) || step_to(1, 1, E_LEFT);
      default:  ;
    endcase
    // no neighbor continues the outline: turn in place
    if (!moved && walk_e != E_NONE) walk_e = rot_edge_e'((int'(walk_e) + 1) & 3);
  endfunction

  function automatic rot_xy_t corner_at(int c, int r, rot_edge_e e);
    rot_xy_t v;
    int      cx;
    int      cy;
    cx = c + ((e == E_TOP || e == E_RIGHT) ? 1 : 0);
    cy = r + ((e == E_BOTTOM || e == E_RIGHT) ? 1 : 0);
    v.x = 16'(cx + int'($signed(org_x)));
    v.y = 16'(cy + int'($signed(org_y)));
    return v;
  endfunction

  function automatic void scan_on();
    scan_c++;
    if (scan_c >= cols_used()) begin
      scan_c = 0;
      scan_r++;
    end
  endfunction

  function automatic bit seek_start();
    rot_edge_e e;
    while (scan_r < rows_used()) begin
      if (scan_c >= cols_used()) begin
        scan_c = 0;
        scan_r++;
        continue;
      end
      // try Top, Left, Bottom, Right
      for (int k = 0; k < 4; k++) begin
        e = rot_edge_e'((int'(E_TOP) + k) & 3);
        if (!edge_seen[scan_r*Dim + scan_c][e] && on_outline(e, scan_c, scan_r)) begin
          first_e = e;
          return 1'b1;
        end
      end
      scan_on();
    end
    return 1'b0;
  endfunction

  // 0 corner, 1 polygon end, 2 frame finished
  function automatic int trace_event(output rot_xy_t v);
    int  idx;
    bit  turned;
    v = '0;
    forever begin
      if (!walking) begin
        if (!seek_start()) return 2;
        walking     = 1'b1;
        walk_c      = scan_c;
        walk_r      = scan_r;
        walk_e      = first_e;
        last_turn_e = E_NONE;
        close_step  = 0;
        walk_shown  = !(drop_holes && first_e == E_BOTTOM);
        if (first_e == E_BOTTOM) begin
          last_turn_e = E_BOTTOM;
          if (walk_shown) begin
            v = corner_at(walk_c, walk_r, E_BOTTOM);
            return 0;
          end
        end
        continue;
      end
      if (close_step == 1) begin
        close_step = 2;
        if (walk_shown) begin
          v = corner_at(scan_c, scan_r, E_NONE);
          return 0;
        end
        continue;
      end
      if (close_step == 2) begin
        walking    = 1'b0;
        close_step = 0;
        scan_on();
        return 1;
      end
      if (walk_e == E_NONE) begin
        close_step = 2;
        continue;
      end
      idx = walk_r*Dim + walk_c;
      // broken outline: an edge already marked ends the polygon
      if (edge_seen[idx][walk_e]) begin
        close_step = 2;
        continue;
      end
      edge_seen[idx][walk_e] = 1'b1;
      walk_edge();
      turned = 1'b0;
      if (last_turn_e != walk_e) begin
        v           = corner_at(walk_c, walk_r, walk_e);
        last_turn_e = walk_e;
        turned      = 1'b1;
      end
      if (walk_r == scan_r && walk_c == scan_c && walk_e == first_e)
        close_step = (first_e != E_BOTTOM) ? 1 : 2;
      if (turned && walk_shown) return 0;
    end
  endfunction

  function automatic void restart_frame();
    foreach (edge_seen[i]) edge_seen[i] = '0;
    scan_c = 0; scan_r = 0; walk_c = 0; walk_r = 0;
    walk_e = E_NONE; last_turn_e = E_NONE; first_e = E_NONE;
    walking = 1'b0; walk_shown = 1'b0; close_step = 0;
    held = 1'b0; held_xy = '0;
  endfunction

  // One next-vertex item: the corner is held back one step so that the
  // closing corner can carry polygon_last.
  function automatic rot_res_t next_corner();
    rot_res_t res;
    rot_xy_t  v;
    int       ev;
    res = '0;
    forever begin
      ev = trace_event(v);
      if (ev == 0) begin
        if (held) begin
          res.xy  = held_xy;
          held_xy = v;
          return res;
        end
        held    = 1'b1;
        held_xy = v;
      end else if (held) begin
        held     = 1'b0;
        res.xy   = held_xy;
        res.last = 1'b1;
        return res;
      end else if (ev == 2) begin
        res.done = 1'b1;
        return res;
      end
    end
  endfunction

  function automatic void accept_item(pix_req_t it);
    rot_res_t res;
    case (it.op)
      OP_WRITE: frame_px[it.row*Dim + it.col] = it.opa;
      OP_FRAME: begin
        restart_frame();
        dones_seen = 0;
      end
      OP_NEXT: begin
        res = next_corner();
        if (res.done) dones_seen++;
        vertex_q = {vertex_q, res};
      end
      default: ;  // unused code: ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: takes items from item_q, predicts each one as it is accepted
  // ---------------------------------------------------------------------
  int in_gap;
  bit in_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    pix_req_t it;
    bit       nv;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      op_i        <= OP_WRITE;
      pixel_col_i <= '0;
      pixel_row_i <= '0;
      opacity_i   <= '0;
      in_gap      <= 0;
      in_calm     <= 1'b0;
    end else begin
      nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        it.op  = rot_op_e'(op_i);
        it.col = pixel_col_i;
        it.row = pixel_row_i;
        it.opa = opacity_i;
        accept_item(it);
        nv = 1'b0;
      end
      if ($urandom_range(0, 299) == 0) in_calm <= !in_calm;
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (item_q.size() > 0) begin
          it          = item_q.pop_front();
          op_i        <= it.op;
          pixel_col_i <= it.col;
          pixel_row_i <= it.row;
          opacity_i   <= it.opa;
          nv          = 1'b1;
          in_gap      <= pick_gap(in_calm);
        end
      end
      in_valid_i <= nv;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compares results, stalls the output side, runs the watchdog
  // ---------------------------------------------------------------------
  int out_gap;
  int idle_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    rot_res_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          $error("result with nothing expected: x %0d y %0d last %0b done %0b",
                 vertex_x_o, vertex_y_o, polygon_last_o, frame_done_o);
          fails++;
        end else begin
          exp_r = vertex_q.pop_front();
          if (vertex_x_o !== $signed(exp_r.xy.x)) begin
            $error("vertex_x expected %0d got %0d", $signed(exp_r.xy.x), vertex_x_o);
            fails++;
          end
          if (vertex_y_o !== $signed(exp_r.xy.y)) begin
            $error("vertex_y expected %0d got %0d", $signed(exp_r.xy.y), vertex_y_o);
            fails++;
          end
          if (polygon_last_o !== exp_r.last) begin
            $error("polygon_last expected %0b got %0b", exp_r.last, polygon_last_o);
            fails++;
          end
          if (frame_done_o !== exp_r.done) begin
            $error("frame_done expected %0b got %0b", exp_r.done, frame_done_o);
            fails++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap     <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_ready_i && $urandom_range(0, 3) == 0) out_gap <= pick_gap(1'b0);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallCap) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic wait_quiet();
    wait (item_q.size() == 0 && !in_valid_i && vertex_q.size() == 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_IMAGE_WIDTH:  act_cols   = val[8:0];
      CFG_IMAGE_HEIGHT: act_rows   = val[8:0];
      CFG_BG_OPACITY:   bg_level   = val[7:0];
      CFG_ORIGIN_X:     org_x      = val;
      CFG_ORIGIN_Y:     org_y      = val;
      CFG_SKIP_HOLES:   drop_holes = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic pix_req_t mk(rot_op_e op, int c, int r, int o);
    pix_req_t it;
    it.op  = op;
    it.col = 8'(c);
    it.row = 8'(r);
    it.opa = 8'(o);
    return it;
  endfunction

  // A random item that disturbs a trace: pixel write or unused op code
  function automatic pix_req_t noise_item();
    if ($urandom_range(0, 2) == 0) return mk(rot_op_e'(2'd3), $urandom, $urandom, $urandom);
    return mk(OP_WRITE, $urandom, $urandom, $urandom);
  endfunction

  // One frame: set up, fill the whole active area, then trace to the end.
  task automatic run_frame(int w, int h, int bg, logic [14:0] ox, logic [14:0] oy,
                           bit sk, bit ring, bit restart_mid);
    int cw;
    int rh;
    int dens;
    int reqs;
    int o;
    wait_quiet();
    write_reg(CFG_IMAGE_WIDTH, 15'(w));
    write_reg(CFG_IMAGE_HEIGHT, 15'(h));
    write_reg(CFG_BG_OPACITY, 15'(bg));
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_SKIP_HOLES, 15'(sk));
    cw   = (w > Dim) ? Dim : w;
    rh   = (h > Dim) ? Dim : h;
    dens = $urandom_range(30, 90);
    for (int r = 0; r < rh; r++)
      for (int c = 0; c < cw; c++) begin
        if (ring)
          o = (r == 1 && c == 1) ? bg : ((c + r) % 2 ? 8'hff : 8'h00);
        else if ($urandom_range(0, 99) < dens)
          o = $urandom;
        else
          o = bg;
        if (ring && o == bg && !(r == 1 && c == 1)) o = bg ^ 8'h80;
        queue_item(mk(OP_WRITE, c, r, o));
      end
    queue_item(mk(OP_FRAME, 0, 0, 0));
    dones_seen = 0;
    reqs = 0;
    // keep asking until the frame reports done twice (or a cap is hit)
    while (dones_seen < 2 && reqs < 250) begin
      wait (item_q.size() < 3);
      if ($urandom_range(0, 19) == 0 && !ring) queue_item(noise_item());
      if (restart_mid && reqs == 3) queue_item(mk(OP_FRAME, 0, 0, 0));
      queue_item(mk(OP_NEXT, $urandom, $urandom, $urandom));
      reqs++;
      if (dones_seen == 0 && reqs >= 250) break;
    end
  endtask

  initial begin
    fails      = 0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_wdata_i = '0;
    frame_px   = '{default: '0};
    act_cols   = 256;
    act_rows   = 256;
    bg_level   = '0;
    org_x      = '0;
    org_y      = '0;
    drop_holes = 1'b0;
    dones_seen = 0;
    restart_frame();
    wait (rst_ni === 1'b1);

    // Directed: ring with a hole, origin extremes, holes shown then dropped,
    // a frame restart in the middle of a trace
    run_frame(3, 3, 0, 15'h4000, 15'h3fff, 1'b0, 1'b1, 1'b0);
    run_frame(3, 3, 255, 15'h3fff, 15'h4000, 1'b1, 1'b1, 1'b1);
    // Size extremes: saturated width, full height, empty frame
    run_frame(511, 1, $urandom_range(0, 255), 15'($urandom), 15'($urandom),
              1'b0, 1'b0, 1'b0);
    run_frame(1, 256, 0, 15'h0, 15'h0, 1'b1, 1'b0, 1'b0);
    run_frame(0, 4, 255, 15'($urandom), 15'($urandom), 1'b0, 1'b0, 1'b0);
    run_frame(2, 0, 0, 15'($urandom), 15'($urandom), 1'b0, 1'b0, 1'b0);
    run_frame(1, 1, 7, 15'($urandom), 15'($urandom), 1'b0, 1'b0, 1'b0);

    // Random small frames
    for (int p = 0; p < 8; p++)
      run_frame($urandom_range(1, 9), $urandom_range(1, 9),
                ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255),
                15'($urandom), 15'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b0);

    wait (item_q.size() == 0 && !in_valid_i && vertex_q.size() == 0);
    repeat (Settle) @(posedge clk_i);
    if (fails == 0 && vertex_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
